FILE: hw/rtl/rrvc_pkg.sv
`default_nettype none

package rrvc_pkg;

  // field widths of the item channels
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 11;
  localparam int unsigned COUNT_W = 11;

  // default number of entries
  localparam int unsigned SIZE_DEFAULT = 1024;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROTATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd2;

  // sequencer to compare/count unit
  typedef struct packed {
    logic clear;
    logic step;
  } match_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rrvc_ram.sv
`default_nettype none

module rrvc_ram #(
  parameter int unsigned WIDTH = rrvc_pkg::VALUE_W,
  parameter int unsigned DEPTH = rrvc_pkg::SIZE_DEFAULT,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns the old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrvc_match.sv
`default_nettype none

module rrvc_match #(
  parameter int unsigned SIZE = rrvc_pkg::SIZE_DEFAULT,
  localparam int unsigned CW = $clog2(SIZE + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rrvc_pkg::match_ctrl_t        ctrl_i,
  input  wire logic [rrvc_pkg::VALUE_W-1:0] rdata_i,
  input  wire logic [rrvc_pkg::VALUE_W-1:0] value_i,
  output logic      [rrvc_pkg::COUNT_W-1:0] count_o
);

  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.step && (rdata_i == value_i)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign count_o = rrvc_pkg::COUNT_W'(cnt_q);

endmodule

`default_nettype wire

FILE: hw/rtl/rrvc_seq.sv
`default_nettype none

module rrvc_seq #(
  parameter int unsigned SIZE = rrvc_pkg::SIZE_DEFAULT,
  localparam int unsigned AW = (SIZE > 1) ? $clog2(SIZE) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [rrvc_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [rrvc_pkg::POS_W-1:0]   position_low_i,
  input  wire logic [rrvc_pkg::POS_W-1:0]   position_high_i,
  input  wire logic [rrvc_pkg::VALUE_W-1:0] item_value_i,
  input  wire logic                         out_free_i,
  output logic                              done_o,
  output logic                              ram_we_o,
  output logic      [AW-1:0]                ram_waddr_o,
  output logic      [rrvc_pkg::VALUE_W-1:0] ram_wdata_o,
  output logic      [AW-1:0]                ram_raddr_o,
  input  wire logic [rrvc_pkg::VALUE_W-1:0] ram_rdata_i,
  output rrvc_pkg::match_ctrl_t             match_ctrl_o,
  output logic      [rrvc_pkg::VALUE_W-1:0] value_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_RUN    = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [rrvc_pkg::MODE_W-1:0]  mode_q;
  logic [AW-1:0]                lo_q, hi_q, ptr_q, ptr_d;
  logic [rrvc_pkg::VALUE_W-1:0] value_q;
  logic                         rd_valid_q, rd_valid_d;
  logic                         rd_last_q;
  logic [AW-1:0]                rd_addr_q;

  logic          accept;
  logic [AW-1:0] pos_a, pos_b, lo_in, hi_in;

  // positions beyond the array clamp to the last entry
  always_comb begin
    if (32'(position_low_i) >= 32'(SIZE)) begin
      pos_a = AW'(SIZE - 1);
    end else begin
      pos_a = AW'(32'(position_low_i));
    end
    if (32'(position_high_i) >= 32'(SIZE)) begin
      pos_b = AW'(SIZE - 1);
    end else begin
      pos_b = AW'(32'(position_high_i));
    end
    // reversed range swaps, a load uses the low position as is
    if ((mode_i != rrvc_pkg::MODE_LOAD) && (pos_b < pos_a)) begin
      lo_in = pos_b;
      hi_in = pos_a;
    end else begin
      lo_in = pos_a;
      hi_in = pos_b;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    rd_valid_d = 1'b0;
    done_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ptr_d = lo_in;
          if (mode_i == rrvc_pkg::MODE_LOAD) begin
            state_d = ST_LOAD;
          end else if ((mode_i == rrvc_pkg::MODE_ROTATE) ||
                       (mode_i == rrvc_pkg::MODE_COUNT)) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_LOAD: begin
        state_d = ST_FINISH;
      end
      ST_RUN: begin
        rd_valid_d = 1'b1;
        if (ptr_q == hi_q) begin
          state_d = ST_DRAIN;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      lo_q    <= lo_in;
      hi_q    <= hi_in;
      value_q <= item_value_i;
    end
    ptr_q     <= ptr_d;
    rd_last_q <= (ptr_q == hi_q);
    rd_addr_q <= ptr_q;
  end

  // rotate: each entry read moves up one place, the top one wraps to the low end
  always_comb begin
    ram_raddr_o = ptr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = lo_q;
    ram_wdata_o = value_q;
    if (state_q == ST_LOAD) begin
      ram_we_o = 1'b1;
    end else if (rd_valid_q && (mode_q == rrvc_pkg::MODE_ROTATE)) begin
      ram_we_o    = 1'b1;
      ram_wdata_o = ram_rdata_i;
      ram_waddr_o = rd_last_q ? lo_q : (rd_addr_q + 1'b1);
    end
  end

  assign match_ctrl_o.clear = accept;
  assign match_ctrl_o.step  = rd_valid_q && (mode_q == rrvc_pkg::MODE_COUNT);
  assign value_o            = value_q;

endmodule

`default_nettype wire

FILE: hw/rtl/range_rotate_value_count_table.sv
// channel | valid       | stall        | payload
// --------+-------------+--------------+------------------------------------------------
// in      | in_valid_i  | in_stall_o   | mode_i, position_low_i, position_high_i,
//         |             |              | item_value_i
// out     | out_valid_o | out_stall_i  | match_count_o
//
// one item at a time; the entry memory port is walked one entry per cycle
// rotate and count: one read (and for rotate one write) of the entry memory
// per entry in range
// reset clears control only; entries are undefined until loaded, no clearing pass
// a stalled result holds in the output register; the next item is accepted meanwhile
// and waits in its final step until the output register frees
`default_nettype none

module range_rotate_value_count_table #(
  parameter int unsigned SIZE = rrvc_pkg::SIZE_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [rrvc_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [rrvc_pkg::POS_W-1:0]   position_low_i,
  input  wire logic [rrvc_pkg::POS_W-1:0]   position_high_i,
  input  wire logic [rrvc_pkg::VALUE_W-1:0] item_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [rrvc_pkg::COUNT_W-1:0] match_count_o
);

  localparam int unsigned AW = (SIZE > 1) ? $clog2(SIZE) : 1;

  // entry memory port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [rrvc_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

  // sequencer to counter
  rrvc_pkg::match_ctrl_t        match_ctrl;
  logic [rrvc_pkg::VALUE_W-1:0] match_value;
  logic [rrvc_pkg::COUNT_W-1:0] count;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [rrvc_pkg::COUNT_W-1:0] match_count_q;
  logic                         out_free, done;

  // the output register can take a result when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  rrvc_seq #(
    .SIZE (SIZE)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .position_low_i  (position_low_i),
    .position_high_i (position_high_i),
    .item_value_i    (item_value_i),
    .out_free_i      (out_free),
    .done_o          (done),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .match_ctrl_o    (match_ctrl),
    .value_o         (match_value)
  );

  rrvc_ram #(
    .WIDTH (rrvc_pkg::VALUE_W),
    .DEPTH (SIZE)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared compare and increment unit, fed one entry per cycle
  rrvc_match #(
    .SIZE (SIZE)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (match_ctrl),
    .rdata_i (ram_rdata),
    .value_i (match_value),
    .count_o (count)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // counter is cleared on acceptance, so load and rotate give zero
  always_ff @(posedge clk_i) begin
    if (done) begin
      match_count_q <= count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = match_count_q;

endmodule

`default_nettype wire
